// ===== src/sm4_block_cipher_top_assert.svh =====
// Assertion macros for the SM4 block cipher RTL, used by the controller.
`ifndef SM4_BLOCK_CIPHER_TOP_ASSERT_SVH
`define SM4_BLOCK_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SM4_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sm4: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SM4_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sm4: next-cycle check failed");

`endif

// ===== src/sm4_pkg.sv =====
// Package: SM4 constants, S-box table, round functions and control types.
`default_nettype none
package sm4_pkg;

   localparam int ROUND_COUNT_DEF = 32;
   localparam int HALF_W          = 64;
   localparam int WORD_W          = 32;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW  = 2'd1;

   localparam logic [WORD_W-1:0] FK0 = 32'ha3b1bac6;
   localparam logic [WORD_W-1:0] FK1 = 32'h56aa3350;
   localparam logic [WORD_W-1:0] FK2 = 32'h677d9197;
   localparam logic [WORD_W-1:0] FK3 = 32'hb27022dc;

   localparam logic [7:0] SBOX [256] = '{
      8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
      8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
      8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
      8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
      8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
      8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
      8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
      8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
      8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
      8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
      8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
      8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
      8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
      8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
      8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
      8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
      8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
      8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
      8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
      8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
      8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
      8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
      8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
      8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
      8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
      8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
      8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
      8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
      8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
      8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
      8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
      8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
   };

   typedef struct packed {
      logic key_start;
      logic blk_start;
      logic kexp_step;
      logic round_step;
      logic out_load;
      logic key_done;
   } sm4_cmd_type;

   typedef struct packed {
      logic keys_ready;
      logic out_busy;
      logic csr_write;
   } sm4_status_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                              input int unsigned n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] sbox_word(input logic [WORD_W-1:0] v);
      return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
   endfunction

   // Linear layer of the data rounds.
   function automatic logic [WORD_W-1:0] lin_data(input logic [WORD_W-1:0] t);
      return t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
   endfunction

   // Linear layer of the key schedule.
   function automatic logic [WORD_W-1:0] lin_key(input logic [WORD_W-1:0] t);
      return t ^ rotl(t, 13) ^ rotl(t, 23);
   endfunction

   // CK word i: byte j is (4i + j) * 7 mod 256, byte 0 most significant.
   function automatic logic [WORD_W-1:0] ck_word(input logic [7:0] i);
      logic [WORD_W-1:0] w;
      logic [7:0]        b;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         b = (i * 8'd4 + 8'(j)) * 8'd7;
         w = {w[WORD_W-9:0], b};
      end
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== src/sm4_req_if.sv =====
// Interface: input block channel (cmd and 128-bit block).
`default_nettype none
interface sm4_req_if import sm4_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [HALF_W-1:0] block_high;
   logic [HALF_W-1:0] block_low;

   modport source (output valid, output cmd, output block_high, output block_low,
                   input ready);
   modport sink (input valid, input cmd, input block_high, input block_low,
                 output ready);
endinterface
`default_nettype wire

// ===== src/sm4_rsp_if.sv =====
// Interface: result block channel (128-bit block).
`default_nettype none
interface sm4_rsp_if import sm4_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] result_high;
   logic [HALF_W-1:0] result_low;

   modport source (output valid, output result_high, output result_low, input ready);
   modport sink (input valid, input result_high, input result_low, output ready);
endinterface
`default_nettype wire

// ===== src/sm4_block_cipher_top.sv =====
// Top level: SM4 128-bit block cipher, one block per item, encrypt or decrypt.
// A new item is accepted only after the previous result is loaded into the result register;
// the single shared round unit does one round per cycle, for one item at a time.
// After a key write the next item waits for round key expansion to finish.
// Reset: synchronous, active high; clears keys, ready flag, controller and output valid.
`default_nettype none
module sm4_block_cipher_top import sm4_pkg::*; #(
   parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   sm4_req_if.sink                req_chan,
   sm4_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   sm4_cmd_type                    ctl_cmd;
   sm4_status_type                 status;
   logic [$clog2(ROUND_COUNT)-1:0] round;
   logic                           req_ready;
   logic                           rsp_valid;
   logic [HALF_W-1:0]              rsp_result_high, rsp_result_low;

   sm4_ctrl #(.ROUND_COUNT(ROUND_COUNT)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .ctl_cmd   (ctl_cmd),
      .round     (round)
   );

   sm4_datapath #(.ROUND_COUNT(ROUND_COUNT)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl_cmd         (ctl_cmd),
      .round           (round),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_chan.cmd),
      .req_block_high  (req_chan.block_high),
      .req_block_low   (req_chan.block_low),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_result_high (rsp_result_high),
      .rsp_result_low  (rsp_result_low)
   );

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.result_high = rsp_result_high;
   assign rsp_chan.result_low  = rsp_result_low;

endmodule
`default_nettype wire

// ===== src/sm4_ctrl.sv =====
// Controller: sequences key expansion, the 32 rounds and the result load.
`default_nettype none
`include "sm4_block_cipher_top_assert.svh"
module sm4_ctrl import sm4_pkg::*; #(
   parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  sm4_status_type                 status,
   output sm4_cmd_type                    ctl_cmd,
   output logic [$clog2(ROUND_COUNT)-1:0] round
);

   localparam int IDX_W = $clog2(ROUND_COUNT);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(ROUND_COUNT - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_KEXP = 2'd1;
   localparam logic [1:0] S_RUN  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] round_ff, round_in;
   logic [2:0]       starts;

   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      ctl_cmd   = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = status.keys_ready;
            round_in  = '0;
            if (req_valid && status.keys_ready) begin
               ctl_cmd.blk_start = 1'b1;
               state_in          = S_RUN;
            end else if (req_valid && !status.csr_write) begin
               ctl_cmd.key_start = 1'b1;
               state_in          = S_KEXP;
            end
         end
         S_KEXP: begin
            ctl_cmd.kexp_step = 1'b1;
            round_in          = round_ff + IDX_W'(1);
            if (status.csr_write) begin
               state_in = S_IDLE;
            end else if (round_ff == LAST) begin
               ctl_cmd.key_done = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_RUN: begin
            ctl_cmd.round_step = 1'b1;
            round_in           = round_ff + IDX_W'(1);
            if (round_ff == LAST) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!status.out_busy) begin
               ctl_cmd.out_load = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

   assign round  = round_ff;
   assign starts = {ctl_cmd.key_start, ctl_cmd.blk_start, ctl_cmd.out_load};

   `SM4_ASSERT_IMP(a_ready_needs_keys, clock, reset, req_ready, status.keys_ready)
   `SM4_ASSERT_IMP(a_single_start, clock, reset, 1'b1, $onehot0(starts))
   `SM4_ASSERT_NXT(a_last_round, clock, reset, state_ff == S_RUN && round_ff == LAST, state_ff == S_FIN)
   `SM4_ASSERT_IMP(a_load_when_free, clock, reset, ctl_cmd.out_load, !status.out_busy)

endmodule
`default_nettype wire

// ===== src/sm4_datapath.sv =====
// Datapath: key registers, round key store, shared round unit, result register.
`default_nettype none
module sm4_datapath import sm4_pkg::*; #(
   parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sm4_cmd_type                    ctl_cmd,
   input  logic [$clog2(ROUND_COUNT)-1:0] round,
   output sm4_status_type                 status,
   input  logic                           csr_we,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata,
   input  logic                           req_cmd,
   input  logic [HALF_W-1:0]              req_block_high,
   input  logic [HALF_W-1:0]              req_block_low,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [HALF_W-1:0]              rsp_result_high,
   output logic [HALF_W-1:0]              rsp_result_low
);

   localparam int IDX_W = $clog2(ROUND_COUNT);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(ROUND_COUNT - 1);

   logic [HALF_W-1:0] key_high_ff, key_low_ff;
   logic              keys_ready_ff, keys_ready_in;
   logic              csr_hit;
   logic              dec_ff;
   logic [WORD_W-1:0] x_ff [4];
   logic [WORD_W-1:0] rk_mem [ROUND_COUNT];
   logic [WORD_W-1:0] rk_ff;
   logic              out_valid_ff, out_valid_in;
   logic [HALF_W-1:0] out_high_ff, out_low_ff;

   logic              dec;
   logic [IDX_W-1:0]  rd_idx, rd_addr;
   logic [WORD_W-1:0] mix, sub, new_word;

   // key registers
   always_comb begin
      csr_hit = 1'b0;
      unique case (csr_index)
         CSR_KEY_HIGH: csr_hit = csr_we;
         CSR_KEY_LOW:  csr_hit = csr_we;
         default:      csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_KEY_HIGH) begin
            key_high_ff <= csr_wdata;
         end
         if (csr_index == CSR_KEY_LOW) begin
            key_low_ff <= csr_wdata;
         end
      end
   end

   assign keys_ready_in = csr_hit ? 1'b0 : (ctl_cmd.key_done ? 1'b1 : keys_ready_ff);

   // shared round unit
   assign mix      = x_ff[1] ^ x_ff[2] ^ x_ff[3] ^
                     (ctl_cmd.kexp_step ? ck_word(8'(round)) : rk_ff);
   assign sub      = sbox_word(mix);
   assign new_word = x_ff[0] ^ (ctl_cmd.kexp_step ? lin_key(sub) : lin_data(sub));

   always_ff @(posedge clock) begin
      if (ctl_cmd.key_start) begin
         x_ff[0] <= key_high_ff[63:32] ^ FK0;
         x_ff[1] <= key_high_ff[31:0]  ^ FK1;
         x_ff[2] <= key_low_ff[63:32]  ^ FK2;
         x_ff[3] <= key_low_ff[31:0]   ^ FK3;
      end else if (ctl_cmd.blk_start) begin
         x_ff[0] <= req_block_high[63:32];
         x_ff[1] <= req_block_high[31:0];
         x_ff[2] <= req_block_low[63:32];
         x_ff[3] <= req_block_low[31:0];
      end else if (ctl_cmd.kexp_step || ctl_cmd.round_step) begin
         x_ff[0] <= x_ff[1];
         x_ff[1] <= x_ff[2];
         x_ff[2] <= x_ff[3];
         x_ff[3] <= new_word;
      end
      if (ctl_cmd.blk_start) begin
         dec_ff <= req_cmd;
      end
   end

   // round key store, read one round ahead
   assign dec     = ctl_cmd.blk_start ? req_cmd : dec_ff;
   assign rd_idx  = ctl_cmd.blk_start ? '0 : round + IDX_W'(1);
   assign rd_addr = dec ? LAST - rd_idx : rd_idx;

   always_ff @(posedge clock) begin
      if (ctl_cmd.kexp_step) begin
         rk_mem[round] <= new_word;
      end
      rk_ff <= rk_mem[rd_addr];
   end

   // result register
   assign out_valid_in = ctl_cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (ctl_cmd.out_load) begin
         out_high_ff <= {x_ff[3], x_ff[2]};
         out_low_ff  <= {x_ff[1], x_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ready_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         keys_ready_ff <= keys_ready_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign status.keys_ready = keys_ready_ff;
   assign status.out_busy   = out_valid_ff && !rsp_ready;
   assign status.csr_write  = csr_hit;

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_high = out_high_ff;
   assign rsp_result_low  = out_low_ff;

endmodule
`default_nettype wire

// ===== bench/sm4_cipher_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard class and command codes for the SM4 block cipher testbench.
package sm4_cipher_tb_pkg;
   import sm4_pkg::*;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   // Register indexes with no register behind them.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int ROUNDS = 32;

   typedef struct packed {
      logic [HALF_W-1:0] hi;
      logic [HALF_W-1:0] lo;
   } cipher_block_type;

   class sm4_block_predictor;
      logic [HALF_W-1:0] key_high;
      logic [HALF_W-1:0] key_low;
      logic [WORD_W-1:0] round_keys [ROUNDS];
      bit                keys_ready;
      cipher_block_type  expected_blocks [$];
      int unsigned       mismatches;

      function new();
         key_high   = '0;
         key_low    = '0;
         keys_ready = 1'b0;
         mismatches = 0;
      endfunction

      function logic [WORD_W-1:0] rot_left(logic [WORD_W-1:0] v, int unsigned n);
         return (v << n) | (v >> (WORD_W - n));
      endfunction

      function logic [WORD_W-1:0] sub_bytes(logic [WORD_W-1:0] v);
         logic [WORD_W-1:0] w;
         for (int b = 0; b < 4; b++)
            w[8*b +: 8] = SBOX[v[8*b +: 8]];
         return w;
      endfunction

      function logic [WORD_W-1:0] key_constant(int unsigned i);
         logic [WORD_W-1:0] w;
         w = '0;
         for (int unsigned j = 0; j < 4; j++)
            w = {w[WORD_W-9:0], 8'((4 * i + j) * 7)};
         return w;
      endfunction

      function void schedule_keys();
         logic [WORD_W-1:0] k [4];
         logic [WORD_W-1:0] t;
         logic [WORD_W-1:0] rk;
         k[0] = key_high[63:32] ^ FK0;
         k[1] = key_high[31:0]  ^ FK1;
         k[2] = key_low[63:32]  ^ FK2;
         k[3] = key_low[31:0]   ^ FK3;
         for (int unsigned i = 0; i < ROUNDS; i++) begin
            t  = sub_bytes(k[1] ^ k[2] ^ k[3] ^ key_constant(i));
            rk = k[0] ^ t ^ rot_left(t, 13) ^ rot_left(t, 23);
            round_keys[i] = rk;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = rk;
         end
         keys_ready = 1'b1;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_KEY_HIGH: begin
               key_high   = val;
               keys_ready = 1'b0;
            end
            CSR_KEY_LOW: begin
               key_low    = val;
               keys_ready = 1'b0;
            end
            default: ;
         endcase
      endfunction

      function void note_block(logic cmd, logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo);
         logic [WORD_W-1:0] x [4];
         logic [WORD_W-1:0] t;
         logic [WORD_W-1:0] rk;
         logic [WORD_W-1:0] nx;
         cipher_block_type  res;
         if (!keys_ready)
            schedule_keys();
         x = '{hi[63:32], hi[31:0], lo[63:32], lo[31:0]};
         for (int unsigned i = 0; i < ROUNDS; i++) begin
            rk = (cmd == CMD_DECRYPT) ? round_keys[ROUNDS - 1 - i] : round_keys[i];
            t  = sub_bytes(x[1] ^ x[2] ^ x[3] ^ rk);
            nx = x[0] ^ t ^ rot_left(t, 2) ^ rot_left(t, 10) ^ rot_left(t, 18) ^
                 rot_left(t, 24);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
         end
         res.hi = {x[3], x[2]};
         res.lo = {x[1], x[0]};
         expected_blocks.push_back(res);
      endfunction

      function void check_block(logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo);
         cipher_block_type want;
         if (expected_blocks.size() == 0) begin
            $error("unexpected result item: %h %h", hi, lo);
            mismatches++;
            return;
         end
         want = expected_blocks.pop_front();
         if (hi !== want.hi) begin
            $error("result_high: expected %h, actual %h", want.hi, hi);
            mismatches++;
         end
         if (lo !== want.lo) begin
            $error("result_low: expected %h, actual %h", want.lo, lo);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ===== bench/sm4_block_cipher_top_tb.sv =====
`timescale 1ns / 100ps
// Top of the SM4 block cipher testbench: clock, reset, stimulus and result checking.
module sm4_block_cipher_top_tb import sm4_pkg::*, sm4_cipher_tb_pkg::*;;

   localparam int unsigned RANDOM_ITEMS = 1700;
   localparam int unsigned CYCLE_LIMIT  = 1000000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bit          steady_flow;
   int unsigned cycle_count = 0;
   int unsigned blocks_sent;

   sm4_block_predictor predictor = new();

   sm4_req_if req ();
   sm4_rsp_if rsp ();

   sm4_block_cipher_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int idle_len();
      int r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [HALF_W-1:0] rand_half();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      predictor.write_reg(idx, data);
   endtask

   // Only called with the block idle.
   task automatic program_key(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
                              input bit wr_hi, input bit wr_lo, input bit wr_spare);
      if (wr_hi)
         csr_write(CSR_KEY_HIGH, hi);
      if (wr_spare)
         csr_write($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, {$urandom, $urandom});
      if (wr_lo)
         csr_write(CSR_KEY_LOW, lo);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_block(input logic cmd, input logic [HALF_W-1:0] hi,
                             input logic [HALF_W-1:0] lo);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.cmd        <= cmd;
      req.block_high <= hi;
      req.block_low  <= lo;
      do
         @(posedge clock);
      while (!req.ready);
      predictor.note_block(cmd, hi, lo);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (predictor.expected_blocks.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : result_sink
      int stall;
      stall = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready)
            predictor.check_block(rsp.result_high, rsp.result_low);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            stall--;
         end else begin
            rsp.ready <= 1'b1;
            stall = idle_len();
         end
      end
   end

   initial begin : stimulus
      logic [HALF_W-1:0] key_hi;
      logic [HALF_W-1:0] key_lo;
      int                sel;
      int                count;

      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_KEY_HIGH;
      csr_wdata      <= '0;
      req.valid      <= 1'b0;
      req.cmd        <= CMD_ENCRYPT;
      req.block_high <= '0;
      req.block_low  <= '0;
      steady_flow     = 1'b1;
      blocks_sent     = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // blocks before any key write use the all-zero reset key
      send_block(CMD_ENCRYPT, '0, '0);
      send_block(CMD_DECRYPT, '0, '0);
      send_block(CMD_ENCRYPT, '1, '1);
      send_block(CMD_DECRYPT, '1, '1);
      send_block(CMD_ENCRYPT, '1, '0);
      send_block(CMD_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      drain();

      // write to an unused index must leave the key schedule alone
      steady_flow = 1'b0;
      program_key('0, '0, 1'b0, 1'b0, 1'b1);
      send_block(CMD_ENCRYPT, '0, '0);
      send_block(CMD_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
      drain();

      program_key(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1, 1'b1, 1'b0);
      send_block(CMD_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
      send_block(CMD_DECRYPT, 64'h681edf34d206965e, 64'h86b3e94f536e4246);
      drain();

      program_key('1, '1, 1'b1, 1'b1, 1'b0);
      send_block(CMD_ENCRYPT, '0, '0);
      send_block(CMD_DECRYPT, '1, '1);
      send_block(CMD_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
      drain();

      program_key('1, '0, 1'b0, 1'b1, 1'b0);
      send_block(CMD_ENCRYPT, '0, '1);
      send_block(CMD_DECRYPT, '1, '0);
      drain();

      program_key('0, '0, 1'b1, 1'b1, 1'b1);
      send_block(CMD_ENCRYPT, '1, '1);
      send_block(CMD_DECRYPT, '0, '0);
      drain();

      while (blocks_sent < RANDOM_ITEMS) begin
         steady_flow = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0: begin
               key_hi = '0;
               key_lo = '0;
            end
            1: begin
               key_hi = '1;
               key_lo = '1;
            end
            2: begin
               key_hi = '0;
               key_lo = '1;
            end
            default: begin
               key_hi = {$urandom, $urandom};
               key_lo = {$urandom, $urandom};
            end
         endcase
         sel = $urandom_range(0, 9);
         if (sel <= 5)
            program_key(key_hi, key_lo, 1'b1, 1'b1, $urandom_range(0, 3) == 0);
         else if (sel == 6)
            program_key(key_hi, key_lo, 1'b1, 1'b0, $urandom_range(0, 3) == 0);
         else if (sel == 7)
            program_key(key_hi, key_lo, 1'b0, 1'b1, $urandom_range(0, 3) == 0);
         else if (sel == 9)
            program_key(key_hi, key_lo, 1'b0, 1'b0, 1'b1);
         count = $urandom_range(10, 120);
         repeat (count) begin
            send_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT,
                       rand_half(), rand_half());
            blocks_sent++;
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (predictor.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/sm4_pkg.sv
src/sm4_req_if.sv
src/sm4_rsp_if.sv
src/sm4_ctrl.sv
src/sm4_datapath.sv
src/sm4_block_cipher_top.sv
bench/sm4_cipher_tb_pkg.sv
bench/sm4_block_cipher_top_tb.sv
